// File: src/sha1he_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
package sha1he_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0][31:0] t_chain;

    localparam int NUM_ROUNDS = 80;
    localparam int BLOCK_WORDS = 16;

    localparam t_chain CHAIN_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;

    // Write port into the block buffer memory.
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        t_word      data;
    } t_buf_wr;

    typedef enum logic [1:0] {
        C_IDLE,
        C_PREF,
        C_ROUND,
        C_ADD
    } t_core_state;

    typedef enum logic [1:0] {
        S_IN,
        S_PAD,
        S_COMP,
        S_OUT
    } t_top_state;

endpackage

// File: src/sha1he_compress.sv
// SHA-1 compression unit: block buffer memory, schedule window and round datapath.
module sha1he_compress (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1he_pkg::t_buf_wr i_wr,
    input  logic               i_start,
    input  logic               i_init,
    output logic               o_done,
    output sha1he_pkg::t_chain o_chain
);

    sha1he_pkg::t_word       r_mem [sha1he_pkg::BLOCK_WORDS];
    sha1he_pkg::t_word       r_rd_data;
    logic [3:0]              rd_addr;

    sha1he_pkg::t_core_state r_state;
    sha1he_pkg::t_core_state n_state;
    logic [6:0]              r_round;
    sha1he_pkg::t_chain      r_vars;
    sha1he_pkg::t_chain      r_chain;
    sha1he_pkg::t_word       r_sched [sha1he_pkg::BLOCK_WORDS];

    sha1he_pkg::t_word       mix;
    sha1he_pkg::t_word       w;
    sha1he_pkg::t_word       f;
    sha1he_pkg::t_word       k;
    sha1he_pkg::t_word       tmp;
    sha1he_pkg::t_word       va, vb, vc, vd, ve;

    assign o_chain = r_chain;
    assign o_done  = (r_state == sha1he_pkg::C_ADD);

    // Prefetch word 0, then stay one word ahead of the round counter.
    assign rd_addr = (r_state == sha1he_pkg::C_PREF) ? 4'd0 : (r_round[3:0] + 4'd1);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        va  = r_vars[0];
        vb  = r_vars[1];
        vc  = r_vars[2];
        vd  = r_vars[3];
        ve  = r_vars[4];
        mix = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
        w   = (r_round < 7'd16) ? r_rd_data : {mix[30:0], mix[31]};
        if (r_round < 7'd20) begin
            f = (vb & vc) | (~vb & vd);
            k = sha1he_pkg::K_0;
        end else if (r_round < 7'd40) begin
            f = vb ^ vc ^ vd;
            k = sha1he_pkg::K_1;
        end else if (r_round < 7'd60) begin
            f = (vb & vc) | (vb & vd) | (vc & vd);
            k = sha1he_pkg::K_2;
        end else begin
            f = vb ^ vc ^ vd;
            k = sha1he_pkg::K_3;
        end
        tmp = {va[26:0], va[31:27]} + f + ve + k + w;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha1he_pkg::C_IDLE: begin
                if (i_start) begin
                    n_state = sha1he_pkg::C_PREF;
                end
            end
            sha1he_pkg::C_PREF: begin
                n_state = sha1he_pkg::C_ROUND;
            end
            sha1he_pkg::C_ROUND: begin
                if (r_round == 7'(sha1he_pkg::NUM_ROUNDS - 1)) begin
                    n_state = sha1he_pkg::C_ADD;
                end
            end
            sha1he_pkg::C_ADD: begin
                n_state = sha1he_pkg::C_IDLE;
            end
            default: begin
                n_state = sha1he_pkg::C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1he_pkg::C_IDLE;
            r_round <= '0;
            r_chain <= sha1he_pkg::CHAIN_IV;
        end else begin
            r_state <= n_state;
            case (r_state)
                sha1he_pkg::C_IDLE: begin
                    if (i_init) begin
                        r_chain <= sha1he_pkg::CHAIN_IV;
                    end
                end
                sha1he_pkg::C_PREF: begin
                    r_round <= '0;
                end
                sha1he_pkg::C_ROUND: begin
                    r_round <= r_round + 7'd1;
                end
                sha1he_pkg::C_ADD: begin
                    for (int i = 0; i < 5; i++) begin
                        r_chain[i] <= r_chain[i] + r_vars[i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working variables and schedule window carry no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == sha1he_pkg::C_PREF) begin
            r_vars <= r_chain;
        end else if (r_state == sha1he_pkg::C_ROUND) begin
            r_vars[4] <= vd;
            r_vars[3] <= vc;
            r_vars[2] <= {vb[1:0], vb[31:2]};
            r_vars[1] <= va;
            r_vars[0] <= tmp;
            for (int i = 0; i < sha1he_pkg::BLOCK_WORDS - 1; i++) begin
                r_sched[i] <= r_sched[i + 1];
            end
            r_sched[sha1he_pkg::BLOCK_WORDS - 1] <= w;
        end
    end

endmodule

// File: src/sha1_hash_engine_top.sv
// Top level of the SHA-1 hash engine: byte intake, padding sequencer and digest output.
//
// The engine hashes a message streamed one byte per input transaction. tdata carries the
// byte, tuser flags whether that byte belongs to the message, and tlast ends the message;
// a transaction with tuser low and tlast high ends a message without a byte, so the empty
// message can be hashed. Bytes are accepted one per cycle while tready is high and packed
// four at a time into a 16-word block buffer memory. When the 64th byte of a block arrives,
// input is held off while the compression unit runs: it prefetches the first buffer word,
// runs the 80 rounds (one round per cycle through a single round datapath) and then folds
// the result into the chaining words. On the end of a message the sequencer appends the
// 0x80 byte, zeros and the 64-bit big-endian bit length at one byte per cycle (up to 72
// bytes), running one or two more compressions, and then presents the five digest words,
// most significant first, on the output stream; tdata holds the word and its index, tlast
// marks the fifth word. The output register lets the next message start while the final
// word still waits. After the fifth word is loaded the chaining words return to the SHA-1
// initial values. The bit length wraps modulo 2^64.
module sha1_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] byte_valid
    input  logic        i_s_tlast,   // last
    // Digest stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        o_m_tlast    // last_word
);

    sha1he_pkg::t_top_state r_state;
    sha1he_pkg::t_top_state n_state;
    logic [5:0]             r_fill;
    logic [5:0]             n_fill;
    logic [60:0]            r_msg_bytes;
    logic [60:0]            n_msg_bytes;
    logic [23:0]            r_acc;
    logic [23:0]            n_acc;
    logic                   r_pad;
    logic                   n_pad;
    logic                   r_pad_first;
    logic                   n_pad_first;
    logic                   r_len_phase;
    logic                   n_len_phase;
    logic [2:0]             r_out_idx;
    logic [2:0]             n_out_idx;
    logic                   r_m_valid;
    logic                   n_m_valid;
    logic [31:0]            r_m_word;
    logic [2:0]             r_m_idx;
    logic                   r_m_last;
    logic                   out_load;

    logic                   s_accept;
    logic                   push_en;
    logic [7:0]             push_byte;
    logic [63:0]            len_bits;
    logic [5:0]             len_shift;
    logic [7:0]             len_byte;
    logic                   core_start;
    logic                   core_init;
    logic                   core_done;
    sha1he_pkg::t_buf_wr    buf_wr;
    sha1he_pkg::t_chain     chain;

    sha1he_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (buf_wr),
        .i_start (core_start),
        .i_init  (core_init),
        .o_done  (core_done),
        .o_chain (chain)
    );

    assign o_s_tready = (r_state == sha1he_pkg::S_IN);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {5'd0, r_m_idx, r_m_word};
    assign o_m_tlast  = r_m_last;

    // Length field byte: byte i of the big-endian length sits at bit 8*(7-i).
    assign len_bits  = {r_msg_bytes, 3'b000};
    assign len_shift = {~r_fill[2:0], 3'b000};
    assign len_byte  = 8'(len_bits >> len_shift);

    // Store a word once its fourth byte arrives; start compression on the last byte of a block.
    assign buf_wr.en   = push_en && (r_fill[1:0] == 2'd3);
    assign buf_wr.addr = r_fill[5:2];
    assign buf_wr.data = {r_acc, push_byte};
    assign core_start  = push_en && (r_fill == sha1he_pkg::BLOCK_LAST);

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_msg_bytes = r_msg_bytes;
        n_acc       = r_acc;
        n_pad       = r_pad;
        n_pad_first = r_pad_first;
        n_len_phase = r_len_phase;
        n_out_idx   = r_out_idx;
        n_m_valid   = r_m_valid;
        out_load    = 1'b0;
        push_en     = 1'b0;
        push_byte   = i_s_tdata;
        core_init   = 1'b0;

        unique case (r_state)
            sha1he_pkg::S_IN: begin
                if (s_accept) begin
                    push_en = i_s_tuser;
                    if (i_s_tuser) begin
                        n_msg_bytes = r_msg_bytes + 61'd1;
                    end
                    if (i_s_tlast) begin
                        n_pad       = 1'b1;
                        n_pad_first = 1'b1;
                        n_len_phase = 1'b0;
                        n_state     = sha1he_pkg::S_PAD;
                    end
                    if (i_s_tuser && (r_fill == sha1he_pkg::BLOCK_LAST)) begin
                        n_state = sha1he_pkg::S_COMP;
                    end
                end
            end
            sha1he_pkg::S_PAD: begin
                push_en     = 1'b1;
                n_pad_first = 1'b0;
                if (r_pad_first) begin
                    push_byte = sha1he_pkg::PAD_BYTE;
                end else if (r_len_phase || (r_fill == sha1he_pkg::LEN_START)) begin
                    push_byte   = len_byte;
                    n_len_phase = 1'b1;
                end else begin
                    push_byte = 8'd0;
                end
                if (r_fill == sha1he_pkg::BLOCK_LAST) begin
                    n_state = sha1he_pkg::S_COMP;
                end
            end
            sha1he_pkg::S_COMP: begin
                if (core_done) begin
                    if (r_len_phase) begin
                        n_state   = sha1he_pkg::S_OUT;
                        n_out_idx = 3'd0;
                    end else if (r_pad) begin
                        n_state = sha1he_pkg::S_PAD;
                    end else begin
                        n_state = sha1he_pkg::S_IN;
                    end
                end
            end
            sha1he_pkg::S_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    out_load  = 1'b1;
                    n_m_valid = 1'b1;
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == 3'd4) begin
                        // Digest handed over: restart the chain for the next message.
                        core_init   = 1'b1;
                        n_state     = sha1he_pkg::S_IN;
                        n_pad       = 1'b0;
                        n_len_phase = 1'b0;
                        n_msg_bytes = '0;
                    end
                end
            end
            default: begin
                n_state = sha1he_pkg::S_IN;
            end
        endcase

        if (push_en) begin
            n_fill = r_fill + 6'd1;
            n_acc  = {r_acc[15:0], push_byte};
        end

        // Drop the output word once taken, unless a new one replaces it.
        if (!out_load && r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha1he_pkg::S_IN;
            r_fill      <= '0;
            r_msg_bytes <= '0;
            r_pad       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_out_idx   <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_msg_bytes <= n_msg_bytes;
            r_pad       <= n_pad;
            r_pad_first <= n_pad_first;
            r_len_phase <= n_len_phase;
            r_out_idx   <= n_out_idx;
            r_m_valid   <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (out_load) begin
            r_m_word <= chain[r_out_idx];
            r_m_idx  <= r_out_idx;
            r_m_last <= (r_out_idx == 3'd4);
        end
    end

endmodule

// File: tb/tb_sha1_hash_engine_top.sv
// Self-checking testbench for the SHA-1 hash engine: byte stream in, digest words out.
module tb_sha1_hash_engine_top;

    // Run control. The limit covers the slowest legal run many times over: every byte
    // waiting out the longest sender gap, a compression for each 64 bytes, up to 72
    // padding bytes and two more compressions per message, and five digest words
    // each behind the longest receiver stall.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BYTES = 300;
    // Message lengths around the padding edges: the length field fits or spills, and
    // full blocks before the tail.
    localparam int PAD_EDGES [6] = '{55, 56, 57, 63, 64, 65};

    // One expected digest transaction.
    typedef struct {
        sha1he_pkg::t_word word;
        logic [2:0]        index;
        logic              last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] data_byte
    logic        i_s_tuser = 1'b0;    // [0] byte_valid
    logic        i_s_tlast = 1'b0;    // last
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;           // [31:0] digest_word, [34:32] word_index, [39:35] zero
    logic        o_m_tlast;           // last_word

    // Predictor state: chaining words, partial block, fill level and byte count.
    sha1he_pkg::t_word hash_chain [5];
    logic [7:0]        block_bytes [64];
    int                block_fill;
    logic [60:0]       msg_byte_count;
    t_digest_word      digest_words_due [$];

    int fail_count = 0;
    int cycle_count = 0;
    bit no_gaps = 1'b0;   // when set, neither side idles

    sha1_hash_engine_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic sha1he_pkg::t_word rotl(sha1he_pkg::t_word x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void load_chain_iv();
        int i;
        for (i = 0; i < 5; i++) hash_chain[i] = sha1he_pkg::CHAIN_IV[i];
    endfunction

    // Run the 80 rounds over the full block and fold the result into the chain.
    function automatic void compress_block_bytes();
        sha1he_pkg::t_word sched [80];
        sha1he_pkg::t_word a, b, c, d, e, f, k, tmp;
        int                r;
        for (r = 0; r < 16; r++) begin
            sched[r] = {block_bytes[4*r], block_bytes[4*r+1],
                        block_bytes[4*r+2], block_bytes[4*r+3]};
        end
        for (r = 16; r < 80; r++) begin
            sched[r] = rotl(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
        end
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1he_pkg::K_0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1he_pkg::K_1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1he_pkg::K_2;
            end else begin
                f = b ^ c ^ d;
                k = sha1he_pkg::K_3;
            end
            tmp = rotl(a, 5) + f + e + k + sched[r];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    function automatic void absorb_byte(logic [7:0] v);
        block_bytes[block_fill] = v;
        block_fill++;
        if (block_fill == 64) begin
            compress_block_bytes();
            block_fill = 0;
        end
    endfunction

    // Advance the predictor by one accepted input transaction; on a message end,
    // pad, queue the five digest words and restart the chain.
    function automatic void hash_item(logic [7:0] data, logic byte_valid, logic last);
        logic [63:0]  bit_len;
        t_digest_word dw;
        int           i;
        if (byte_valid) begin
            absorb_byte(data);
            msg_byte_count = msg_byte_count + 61'd1;
        end
        if (!last) return;
        bit_len = {msg_byte_count, 3'b000};
        absorb_byte(sha1he_pkg::PAD_BYTE);
        while (block_fill != int'(sha1he_pkg::LEN_START)) absorb_byte(8'h00);
        for (i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
        for (i = 0; i < 5; i++) begin
            dw.word  = hash_chain[i];
            dw.index = 3'(i);
            dw.last  = (i == 4);
            digest_words_due.push_back(dw);
        end
        load_chain_iv();
        block_fill = 0;
        msg_byte_count = '0;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Drive one input transaction after a random gap and hold it until accepted.
    // Valid drops only during a gap, so it is never lowered and raised in one step.
    task automatic send_item(logic [7:0] data, logic byte_valid, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            i_s_tuser  <= 1'($urandom);
            i_s_tlast  <= 1'($urandom);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= byte_valid;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        hash_item(data, byte_valid, last);
    endtask

    // Empty messages: the tail marker alone, twice in a row.
    task automatic test_empty_message();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
    endtask

    // Short message whose final byte carries the end marker.
    task automatic test_abc_message();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    // Extreme bytes, idle transactions in a message, an empty tail, then two one-byte messages.
    task automatic test_idle_and_extremes();
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // Whole messages with random content: mostly short, some around the padding edges
    // and a few around two full blocks; idle transactions mixed in as noise.
    task automatic test_random_messages();
        int sent;
        int len;
        int pick;
        int i;
        bit end_on_byte;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) len = $urandom_range(0, 8);
            else if (pick < 16) len = PAD_EDGES[$urandom_range(0, 5)];
            else if (pick < 17) len = $urandom_range(119, 129);
            else len = $urandom_range(9, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            end_on_byte = (len != 0) && $urandom_range(0, 1);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
                sent++;
            end
            if (!end_on_byte) begin
                send_item(8'($urandom), 1'b0, 1'b1);
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------- digest side

    // Stall the digest stream for a random number of cycles before each transaction.
    always begin : digest_sink
        int stall;
        stall = no_gaps ? 0 : $urandom_range(0, 9);
        repeat (stall) begin
            @(negedge i_clk);
            i_m_tready <= 1'b0;
        end
        @(negedge i_clk);
        i_m_tready <= 1'b1;
        do @(posedge i_clk); while (!(i_rst_n && o_m_tvalid));
    end

    function automatic void check_field(string name, logic [31:0] due, logic [31:0] seen);
        if (seen !== due) begin
            $display("%0t: digest %s mismatch: expected %0h, actual %0h",
                     $time, name, due, seen);
            fail_count++;
        end
    endfunction

    // Compare each accepted digest transaction with the oldest expected word.
    always @(posedge i_clk) begin : digest_check
        t_digest_word due;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (digest_words_due.size() == 0) begin
                $display("%0t: unexpected digest transaction: expected none, actual %h",
                         $time, o_m_tdata);
                fail_count++;
            end else begin
                due = digest_words_due.pop_front();
                check_field("word", due.word, o_m_tdata[31:0]);
                check_field("index", 32'(due.index), 32'(o_m_tdata[34:32]));
                check_field("last", 32'(due.last), 32'(o_m_tlast));
                check_field("pad bits", 32'd0, 32'(o_m_tdata[39:35]));
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        load_chain_iv();
        block_fill = 0;
        msg_byte_count = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_abc_message();
        test_idle_and_extremes();
        test_random_messages();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // Drain outstanding digests, then watch for stray output.
        while (digest_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sha1_hash_engine_top.f
src/sha1he_pkg.sv
src/sha1he_compress.sv
src/sha1_hash_engine_top.sv
tb/tb_sha1_hash_engine_top.sv
